// File: src/jpeg_marker_remap_rewriter_top_defines.svh
// Assertion macros shared by the rewriter modules.
`ifndef JPEG_MARKER_REMAP_REWRITER_TOP_DEFINES_SVH
`define JPEG_MARKER_REMAP_REWRITER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JMRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define JMRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/jmrr_pkg.sv
// Types, codes and tables for the marker remap rewriter.
package jmrr_pkg;

	localparam int MAX_RES = 5;
	localparam int CNT_W = 3;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_LEN_HI = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_BODY   = 3'd3,
		PH_MARK   = 3'd4,
		PH_DATA   = 3'd5,
		PH_DONE   = 3'd6,
		PH_FAIL   = 3'd7
	} phase_t;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_HDR   = 3'd1;
	localparam logic [2:0] ERR_NO_FF    = 3'd2;
	localparam logic [2:0] ERR_SHORT    = 3'd3;
	localparam logic [2:0] ERR_NO_EOI   = 3'd4;

	localparam logic [7:0] MK_FF  = 8'hff;
	localparam logic [7:0] MK_SOI = 8'hd8;
	localparam logic [7:0] MK_APP = 8'he0;
	localparam logic [7:0] MK_DHT = 8'hc4;
	localparam logic [7:0] MK_SOS = 8'hda;
	localparam logic [7:0] MK_EOI = 8'hd9;
	localparam logic [7:0] SRC_EOI = 8'hc9;
	localparam logic [7:0] SRC_SOI = 8'hc8;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       eoi;
		logic [2:0] err;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] list;
		cnt_t               count;
	} step_out_t;

	function automatic res_t mk_res(input logic [7:0] data, input logic [1:0] kind,
			input logic eoi, input logic [2:0] err);
		res_t r;
		r.data = data;
		r.kind = kind;
		r.eoi  = eoi;
		r.err  = err;
		return r;
	endfunction

	function automatic logic [7:0] remap_code(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'ha0:   r = 8'hc0;
			8'ha4:   r = 8'hc4;
			8'hc8:   r = 8'hd8;
			8'hc9:   r = 8'hd9;
			8'hca:   r = 8'hda;
			8'hcb:   r = 8'hdb;
			8'hd0:   r = 8'he0;
			default: r = 8'hfe;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hunt_byte(input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0:    r = 8'hff;
			2'd1:    r = 8'hc8;
			2'd2:    r = 8'hff;
			default: r = 8'hd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] jfif_byte(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0:    r = 8'h4a;
			3'd1:    r = 8'h46;
			3'd2:    r = 8'h49;
			3'd3:    r = 8'h46;
			3'd5:    r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: src/jmrr_step.sv
// Parser state and per-byte result list of the marker remap rewriter.
`include "jpeg_marker_remap_rewriter_top_defines.svh"

module jmrr_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            in_byte,
	input  logic                  last_byte,
	output jmrr_pkg::step_out_t   res
);
	import jmrr_pkg::*;

	phase_t      phase_q, phase_n;
	logic [1:0]  pm_q, pm_n;
	logic [3:0]  hoff_q, hoff_n;
	logic [16:0] seg_q, seg_n;
	logic [7:0]  lhh_q, lhh_n;
	logic        huff_q, huff_n;
	logic        pff_q, pff_n;

	logic [7:0]  b;
	logic [15:0] len;
	logic [7:0]  code;
	cnt_t        n;
	res_t [MAX_RES-1:0] list;
	logic [3:0]  hsub;

	always_comb begin
		b = in_byte;
		hsub = hoff_q - 4'd6;
		if (hoff_q >= 4'd6 && hoff_q <= 4'd12)
			b = jfif_byte(hsub[2:0]);
		hoff_n = hoff_q;
		if (hoff_q != 4'd0 && hoff_q < 4'd13)
			hoff_n = hoff_q + 4'd1;
		phase_n = phase_q;
		pm_n = pm_q;
		seg_n = seg_q;
		lhh_n = lhh_q;
		huff_n = huff_q;
		pff_n = pff_q;
		len = {lhh_q, b};
		code = remap_code(b);
		list = '0;
		n = '0;

		case (phase_q)
			PH_HUNT: begin
				if (b == hunt_byte(pm_q)) begin
					if (pm_q == 2'd3) begin
						list[0] = mk_res(MK_FF, KIND_BYTE, 1'b0, ERR_NONE);
						list[1] = mk_res(MK_SOI, KIND_BYTE, 1'b0, ERR_NONE);
						list[2] = mk_res(MK_FF, KIND_BYTE, 1'b0, ERR_NONE);
						list[3] = mk_res(MK_APP, KIND_BYTE, 1'b0, ERR_NONE);
						n = 3'd4;
						pm_n = 2'd0;
						hoff_n = 4'd4;
						phase_n = PH_LEN_HI;
					end else begin
						pm_n = pm_q + 2'd1;
					end
				end else if (b == MK_FF) begin
					pm_n = 2'd1;
				end else if (pm_q == 2'd3 && b == SRC_SOI) begin
					pm_n = 2'd2;
				end else begin
					pm_n = 2'd0;
				end
			end
			PH_LEN_HI: begin
				list[0] = mk_res(b, KIND_BYTE, 1'b0, ERR_NONE);
				n = 3'd1;
				lhh_n = b;
				phase_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (len < 16'd2) begin
					list[0] = mk_res(8'h00, KIND_STATUS, 1'b0, ERR_SHORT);
					n = 3'd1;
					phase_n = PH_FAIL;
				end else begin
					list[0] = mk_res(b, KIND_BYTE, 1'b0, ERR_NONE);
					n = 3'd1;
					seg_n = {1'b0, len} - 17'd2;
					phase_n = (len == 16'd2) ? PH_MARK : PH_BODY;
				end
			end
			PH_BODY: begin
				list[0] = mk_res(b, KIND_BYTE, 1'b0, ERR_NONE);
				n = 3'd1;
				seg_n = seg_q - 17'd1;
				if (seg_q == 17'd1)
					phase_n = PH_MARK;
			end
			PH_MARK: begin
				if (!pff_q) begin
					if (b == MK_FF) begin
						pff_n = 1'b1;
					end else begin
						list[0] = mk_res(8'h00, KIND_STATUS, 1'b0, ERR_NO_FF);
						n = 3'd1;
						phase_n = PH_FAIL;
					end
				end else begin
					pff_n = 1'b0;
					if (code == MK_DHT)
						huff_n = 1'b1;
					if (code == MK_SOS) begin
						if (!huff_q) begin
							list[0] = mk_res(8'h00, KIND_INSERT, 1'b0, ERR_NONE);
							list[1] = mk_res(MK_FF, KIND_BYTE, 1'b0, ERR_NONE);
							list[2] = mk_res(MK_SOS, KIND_BYTE, 1'b0, ERR_NONE);
							n = 3'd3;
						end else begin
							list[0] = mk_res(MK_FF, KIND_BYTE, 1'b0, ERR_NONE);
							list[1] = mk_res(MK_SOS, KIND_BYTE, 1'b0, ERR_NONE);
							n = 3'd2;
						end
						phase_n = PH_DATA;
					end else begin
						list[0] = mk_res(MK_FF, KIND_BYTE, 1'b0, ERR_NONE);
						list[1] = mk_res(code, KIND_BYTE, 1'b0, ERR_NONE);
						n = 3'd2;
						phase_n = PH_LEN_HI;
					end
				end
			end
			PH_DATA: begin
				if (pff_q && b == SRC_EOI) begin
					list[0] = mk_res(MK_EOI, KIND_BYTE, 1'b1, ERR_NONE);
					n = 3'd1;
					pff_n = 1'b0;
					phase_n = PH_DONE;
				end else begin
					list[0] = mk_res(b, KIND_BYTE, 1'b0, ERR_NONE);
					n = 3'd1;
					pff_n = (b == MK_FF);
				end
			end
			default: begin
			end
		endcase

		if (last_byte) begin
			if (phase_n == PH_HUNT) begin
				list[n] = mk_res(8'h00, KIND_STATUS, 1'b0, ERR_NO_HDR);
				n = n + 3'd1;
			end else if (phase_n != PH_DONE && phase_n != PH_FAIL) begin
				list[n] = mk_res(8'h00, KIND_STATUS, 1'b0, ERR_NO_EOI);
				n = n + 3'd1;
			end
			phase_n = PH_HUNT;
			pm_n = 2'd0;
			hoff_n = 4'd0;
			seg_n = 17'd0;
			lhh_n = 8'd0;
			huff_n = 1'b0;
			pff_n = 1'b0;
		end

		res.list = list;
		res.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pm_q <= 2'd0;
			hoff_q <= 4'd0;
			seg_q <= 17'd0;
			lhh_q <= 8'd0;
			huff_q <= 1'b0;
			pff_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			pm_q <= pm_n;
			hoff_q <= hoff_n;
			seg_q <= seg_n;
			lhh_q <= lhh_n;
			huff_q <= huff_n;
			pff_q <= pff_n;
		end
	end

	`JMRR_ASSERT_NOW(a_pm_hunt_only, phase_q != PH_HUNT, pm_q == 2'd0, "match count outside hunt")
	`JMRR_ASSERT_NOW(a_hoff_sat, 1'b1, hoff_q <= 4'd13, "header offset past saturation")
	`JMRR_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE && !(fire && last_byte), phase_q == PH_DONE, "left done without end of input")
	`JMRR_ASSERT_NOW(a_seg_body, phase_q == PH_BODY, seg_q != 17'd0, "body with nothing remaining")

endmodule

// File: src/jpeg_marker_remap_rewriter_top.sv
// Top level of the marker remap rewriter: input register, parser, result buffer.
//
// channel | beat                                   | handshake
// src     | in_byte, last_byte                     | src_valid / src_stall
// res     | out_byte, out_kind, image_end, error_code | res_valid / res_stall
//
// A source byte is registered and parsed, and its 0 to 5 results land in a result buffer
// that drains one beat per cycle while res_stall is low; then single-result bytes flow at one
// per cycle. A byte with several results holds the buffer until its last result is taken.
// arst_n clears all parser state and both buffers; the next byte starts a new file.
// res_stall backs up into src_stall through the result buffer and the input register.
`include "jpeg_marker_remap_rewriter_top_defines.svh"

module jpeg_marker_remap_rewriter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       image_end,
	output logic [2:0] error_code
);
	import jmrr_pkg::*;

	logic        s1_valid_q;
	logic [7:0]  byte_s1;
	logic        last_s1;
	res_t [MAX_RES-1:0] buf_q;
	cnt_t        cnt_q, idx_q;
	step_out_t   step_res;
	res_t        cur;
	logic        take, free, move, src_acc;

	jmrr_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (move),
		.in_byte   (byte_s1),
		.last_byte (last_s1),
		.res       (step_res)
	);

	assign res_valid = idx_q != cnt_q;
	assign take = res_valid && !res_stall;
	assign free = !res_valid || (take && (idx_q + 3'd1 == cnt_q));
	assign move = s1_valid_q && free;
	assign src_stall = s1_valid_q && !move;
	assign src_acc = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (src_acc) begin
			s1_valid_q <= 1'b1;
		end else if (move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (move) begin
			cnt_q <= step_res.count;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (move)
			buf_q <= step_res.list;
	end

	always_comb begin
		cur = buf_q[0];
		case (idx_q)
			3'd1:    cur = buf_q[1];
			3'd2:    cur = buf_q[2];
			3'd3:    cur = buf_q[3];
			3'd4:    cur = buf_q[4];
			default: cur = buf_q[0];
		endcase
	end

	assign out_byte = cur.data;
	assign out_kind = cur.kind;
	assign image_end = cur.eoi;
	assign error_code = cur.err;

	`JMRR_ASSERT_NOW(a_idx_bound, 1'b1, idx_q <= cnt_q && cnt_q <= 3'd5, "result index past count")
	`JMRR_ASSERT_NOW(a_stall_full, src_stall, s1_valid_q, "stall with empty input register")
	`JMRR_ASSERT_NOW(a_status_err, res_valid && out_kind == KIND_STATUS, error_code != ERR_NONE, "status beat without error")
	`JMRR_ASSERT_NOW(a_kind_legal, res_valid, out_kind != 2'd3, "undefined result kind")

endmodule

// File: tb/tb_jpeg_marker_remap_rewriter_top.sv
// Testbench for the marker remap rewriter: directed and random source files checked beat by beat.
module tb_jpeg_marker_remap_rewriter_top;
	import jmrr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 300;

	localparam logic [7:0] SRC_SOF = 8'ha0;
	localparam logic [7:0] SRC_DHT = 8'ha4;
	localparam logic [7:0] SRC_SOS = 8'hca;
	localparam logic [7:0] SRC_DQT = 8'hcb;
	localparam logic [7:0] SRC_APP = 8'hd0;
	localparam logic [7:0] MK_SOF  = 8'hc0;
	localparam logic [7:0] MK_DQT  = 8'hdb;
	localparam logic [7:0] MK_COM  = 8'hfe;

	localparam int FLAW_NONE  = 0;
	localparam int FLAW_SHORT = 1;
	localparam int FLAW_TRUNC = 2;
	localparam int FLAW_CORRUPT = 3;
	localparam int FLAW_NOISE = 4;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	logic [7:0] in_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic       image_end;
	logic [2:0] error_code;

	jpeg_marker_remap_rewriter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.in_byte    (in_byte),
		.last_byte  (last_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.image_end  (image_end),
		.error_code (error_code)
	);

	// rewriter state mirror
	phase_t      ph;
	logic [1:0]  hunt_cnt;
	logic [3:0]  hdr_off;
	logic [16:0] seg_left;
	logic [7:0]  len_hi;
	logic        dht_seen;
	logic        prev_ff;

	res_t        expected_jfif[$];
	logic [7:0]  file_bytes[$];
	int          fail_cnt = 0;
	int          cycle_cnt = 0;
	bit          tx_gaps_on = 1'b1;
	bit          rx_gaps_on = 1'b1;
	bit          long_hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] jfif_fill(input logic [3:0] off);
		case (off)
			4'd6:    return 8'h4a;
			4'd7:    return 8'h46;
			4'd8:    return 8'h49;
			4'd9:    return 8'h46;
			4'd11:   return 8'h01;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] hunt_at(input logic [1:0] idx);
		if (idx == 2'd3)
			return SRC_APP;
		return idx[0] ? SRC_SOI : MK_FF;
	endfunction

	function automatic logic [7:0] remap_marker(input logic [7:0] c);
		case (c)
			SRC_SOF: return MK_SOF;
			SRC_DHT: return MK_DHT;
			SRC_SOI: return MK_SOI;
			SRC_EOI: return MK_EOI;
			SRC_SOS: return MK_SOS;
			SRC_DQT: return MK_DQT;
			SRC_APP: return MK_APP;
			default: return MK_COM;
		endcase
	endfunction

	task automatic add_beat(input logic [7:0] d, input logic [1:0] k, input logic e,
			input logic [2:0] c);
		res_t r;
		r.data = d;
		r.kind = k;
		r.eoi  = e;
		r.err  = c;
		expected_jfif.push_back(r);
	endtask

	task automatic add_byte(input logic [7:0] d);
		add_beat(d, KIND_BYTE, 1'b0, ERR_NONE);
	endtask

	task automatic add_status(input logic [2:0] c);
		add_beat(8'h00, KIND_STATUS, 1'b0, c);
	endtask

	task automatic clear_rewriter;
		ph = PH_HUNT;
		hunt_cnt = 2'd0;
		hdr_off = 4'd0;
		seg_left = 17'd0;
		len_hi = 8'h00;
		dht_seen = 1'b0;
		prev_ff = 1'b0;
	endtask

	task automatic rewrite_byte(input logic [7:0] raw, input logic fin);
		logic [7:0]  b;
		logic [7:0]  code;
		logic [16:0] seg_len;
		b = raw;
		if (hdr_off >= 4'd6 && hdr_off <= 4'd12)
			b = jfif_fill(hdr_off);
		if (hdr_off != 4'd0 && hdr_off < 4'd13)
			hdr_off = hdr_off + 4'd1;
		case (ph)
			PH_HUNT: begin
				if (b == hunt_at(hunt_cnt)) begin
					if (hunt_cnt == 2'd3) begin
						add_byte(MK_FF);
						add_byte(MK_SOI);
						add_byte(MK_FF);
						add_byte(MK_APP);
						hunt_cnt = 2'd0;
						hdr_off = 4'd4;
						ph = PH_LEN_HI;
					end else begin
						hunt_cnt = hunt_cnt + 2'd1;
					end
				end else if (b == MK_FF) begin
					hunt_cnt = 2'd1;
				end else if (hunt_cnt == 2'd3 && b == SRC_SOI) begin
					hunt_cnt = 2'd2;
				end else begin
					hunt_cnt = 2'd0;
				end
			end
			PH_LEN_HI: begin
				add_byte(b);
				len_hi = b;
				ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				seg_len = {1'b0, len_hi, b};
				if (seg_len < 17'd2) begin
					add_status(ERR_SHORT);
					ph = PH_FAIL;
				end else begin
					add_byte(b);
					seg_left = seg_len - 17'd2;
					ph = (seg_left != 17'd0) ? PH_BODY : PH_MARK;
				end
			end
			PH_BODY: begin
				add_byte(b);
				seg_left = seg_left - 17'd1;
				if (seg_left == 17'd0)
					ph = PH_MARK;
			end
			PH_MARK: begin
				if (!prev_ff) begin
					if (b == MK_FF) begin
						prev_ff = 1'b1;
					end else begin
						add_status(ERR_NO_FF);
						ph = PH_FAIL;
					end
				end else begin
					prev_ff = 1'b0;
					code = remap_marker(b);
					if (code == MK_DHT)
						dht_seen = 1'b1;
					if (code == MK_SOS) begin
						if (!dht_seen)
							add_beat(8'h00, KIND_INSERT, 1'b0, ERR_NONE);
						add_byte(MK_FF);
						add_byte(MK_SOS);
						ph = PH_DATA;
					end else begin
						add_byte(MK_FF);
						add_byte(code);
						ph = PH_LEN_HI;
					end
				end
			end
			PH_DATA: begin
				if (prev_ff && b == SRC_EOI) begin
					add_beat(MK_EOI, KIND_BYTE, 1'b1, ERR_NONE);
					prev_ff = 1'b0;
					ph = PH_DONE;
				end else begin
					add_byte(b);
					prev_ff = (b == MK_FF);
				end
			end
			default: ;
		endcase
		if (fin) begin
			if (ph == PH_HUNT)
				add_status(ERR_NO_HDR);
			else if (ph != PH_DONE && ph != PH_FAIL)
				add_status(ERR_NO_EOI);
			clear_rewriter();
		end
	endtask

	// one source beat; returns right after the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		src_valid <= 1'b1;
		in_byte <= b;
		last_byte <= fin;
		forever begin
			@(negedge clk);
			if (!src_stall)
				break;
		end
		@(posedge clk);
		rewrite_byte(b, fin);
	endtask

	task automatic send_file;
		int i;
		for (i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	task automatic build_file(input int flaw);
		int n_seg;
		int seg_len;
		int i;
		int cut;
		logic [7:0] code;
		file_bytes.delete();
		if (flaw == FLAW_NOISE) begin
			repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
		file_bytes.push_back(MK_FF);
		file_bytes.push_back(SRC_SOI);
		file_bytes.push_back(MK_FF);
		file_bytes.push_back(SRC_APP);
		seg_len = $urandom_range(9, 14);
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'(seg_len));
		repeat (seg_len - 2) file_bytes.push_back(8'($urandom_range(0, 255)));
		n_seg = $urandom_range((flaw == FLAW_SHORT) ? 1 : 0, 3);
		for (i = 0; i < n_seg; i++) begin
			case ($urandom_range(0, 4))
				0:       code = SRC_SOF;
				1:       code = SRC_DHT;
				2:       code = SRC_DQT;
				3:       code = SRC_APP;
				default: code = 8'($urandom_range(0, 255));
			endcase
			file_bytes.push_back(MK_FF);
			file_bytes.push_back(code);
			seg_len = (flaw == FLAW_SHORT && i == 0) ? $urandom_range(0, 1)
				: $urandom_range(2, 6);
			file_bytes.push_back(8'h00);
			file_bytes.push_back(8'(seg_len));
			if (seg_len > 2)
				repeat (seg_len - 2) file_bytes.push_back(8'($urandom_range(0, 255)));
		end
		file_bytes.push_back(MK_FF);
		file_bytes.push_back(SRC_SOS);
		repeat ($urandom_range(1, 10)) file_bytes.push_back(8'($urandom_range(0, 255)));
		file_bytes.push_back(MK_FF);
		file_bytes.push_back(SRC_EOI);
		repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom_range(0, 255)));
		if (flaw == FLAW_TRUNC) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end else if (flaw == FLAW_CORRUPT) begin
			file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		end
	endtask

	task automatic send_random_files(input int budget);
		int r;
		int flaw;
		int sent;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 9);
			flaw = (r <= 5) ? FLAW_NONE : (r == 6) ? FLAW_SHORT : (r == 7) ? FLAW_TRUNC
				: (r == 8) ? FLAW_CORRUPT : FLAW_NOISE;
			build_file(flaw);
			sent += file_bytes.size();
			send_file();
		end
	endtask

	task automatic test_no_header;
		file_bytes = '{8'hff, 8'hc8, 8'hff, 8'hc8, 8'h00};
		send_file();
	endtask

	// no Huffman table before scan start, trailing byte after end marker
	task automatic test_default_table;
		file_bytes = '{8'hff, 8'hc8, 8'hff, 8'hd0, 8'h00, 8'h09, 8'h00, 8'hff, 8'h80,
			8'h7f, 8'h01, 8'hfe, 8'haa, 8'hff, 8'hca, 8'hff, 8'hc9, 8'h55};
		send_file();
	endtask

	// marker lands in the forced JFIF id bytes
	task automatic test_header_overwrite;
		file_bytes = '{8'hff, 8'hc8, 8'hff, 8'hd0, 8'h00, 8'h02, 8'hff, 8'hd0};
		send_file();
	endtask

	task automatic test_short_length;
		file_bytes = '{8'hff, 8'hc8, 8'hff, 8'hd0, 8'h00, 8'($urandom_range(0, 1))};
		send_file();
	endtask

	task automatic test_no_end;
		file_bytes = '{8'hff, 8'hc8, 8'hff, 8'hd0, 8'h00};
		send_file();
	endtask

	task automatic test_random_files;
		send_random_files(40);
	endtask

	task automatic test_backpressure;
		long_hold_req = 1'b1;
		build_file(FLAW_NONE);
		send_file();
	endtask

	task automatic test_streaming;
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		send_random_files(20);
	endtask

	// result side: stall bursts and one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
				res_stall <= 1'b0;
			end else if (rx_gaps_on && arst_n && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	res_t want;

	always @(negedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_jfif.size() == 0) begin
				$error("unexpected beat: out_byte %h out_kind %0d image_end %0d error_code %0d",
					out_byte, out_kind, image_end, error_code);
				fail_cnt++;
			end else begin
				want = expected_jfif.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte expected %h actual %h", want.data, out_byte);
					fail_cnt++;
				end
				if (out_kind !== want.kind) begin
					$error("out_kind expected %0d actual %0d", want.kind, out_kind);
					fail_cnt++;
				end
				if (image_end !== want.eoi) begin
					$error("image_end expected %0d actual %0d", want.eoi, image_end);
					fail_cnt++;
				end
				if (error_code !== want.err) begin
					$error("error_code expected %0d actual %0d", want.err, error_code);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		clear_rewriter();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_no_header();
		test_default_table();
		test_header_overwrite();
		test_short_length();
		test_no_end();
		test_random_files();
		test_backpressure();
		test_streaming();
		src_valid <= 1'b0;
		while (expected_jfif.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_jfif.size() != 0) begin
			$error("%0d expected beats never arrived", expected_jfif.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/jmrr_pkg.sv
src/jmrr_step.sv
src/jpeg_marker_remap_rewriter_top.sv
tb/tb_jpeg_marker_remap_rewriter_top.sv
